@@ src/mgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion gesture classifier package
// Window sizes, field widths, register codes and result codes shared by the
// interfaces and the classifier.
// ----------------------------------------------------------------------------
package mgc_pkg;

    localparam int ACCEL_WINDOW = 5;
    localparam int RATE_WINDOW  = 2;

    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int GRAV_W     = 15;
    localparam int THR_W      = 15;
    localparam int WIN_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ORIENT_W   = 2;
    localparam int ROT_W      = 2;

    localparam int ACCEL_SLOT_W = (ACCEL_WINDOW > 1) ? $clog2(ACCEL_WINDOW) : 1;
    localparam int RATE_SLOT_W  = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;

    // Window sums and scaled thresholds.
    localparam int ACC_SUM_W  = SAMPLE_W + $clog2(ACCEL_WINDOW);
    localparam int RATE_SUM_W = SAMPLE_W + $clog2(RATE_WINDOW);
    localparam int GW_W       = GRAV_W + $clog2(ACCEL_WINDOW);
    localparam int LIM_W      = THR_W + $clog2(RATE_WINDOW);
    localparam int CMP_W      = GW_W + 3;
    localparam int XY_W       = 2 * ACC_SUM_W + 2;
    localparam int RCMP_W     = RATE_SUM_W + 1;

    localparam int GRAVITY_RESET      = 2511;
    localparam int ROT_THR_RESET      = 64;
    localparam int SHAKE_LIMIT_RESET  = 320;
    localparam int SHAKE_WINDOW_RESET = 500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY      = 2'd0,
        CFG_ROT_THR      = 2'd1,
        CFG_SHAKE_LIMIT  = 2'd2,
        CFG_SHAKE_WINDOW = 2'd3
    } cfg_index_t;

    typedef enum logic [ORIENT_W-1:0] {
        ORIENT_UNKNOWN    = 2'd0,
        ORIENT_UPRIGHT    = 2'd1,
        ORIENT_INVERTED   = 2'd2,
        ORIENT_HORIZONTAL = 2'd3
    } orient_t;

    typedef enum logic [ROT_W-1:0] {
        ROT_NONE = 2'd0,
        ROT_POS  = 2'd1,
        ROT_NEG  = 2'd2
    } rotation_t;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_DOWN = 2'd1,
        PHASE_UP   = 2'd2
    } shake_phase_t;

endpackage

@@ src/mgc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion gesture classifier channels
// Valid/ready channels for one sensor sample and for one classification word.
// ----------------------------------------------------------------------------
interface mgc_sample_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [mgc_pkg::SAMPLE_W-1:0]    accel_x;
    logic signed [mgc_pkg::SAMPLE_W-1:0]    accel_y;
    logic signed [mgc_pkg::SAMPLE_W-1:0]    accel_z;
    logic signed [mgc_pkg::SAMPLE_W-1:0]    rate_x;
    logic signed [mgc_pkg::SAMPLE_W-1:0]    rate_y;
    logic signed [mgc_pkg::SAMPLE_W-1:0]    rate_z;
    logic        [mgc_pkg::TIME_W-1:0]      time_ms;

    modport source (
        output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, time_ms,
        output ready
    );
endinterface

interface mgc_result_if;
    logic                               valid;
    logic                               ready;
    logic [mgc_pkg::ORIENT_W-1:0]       orientation;
    logic [mgc_pkg::ROT_W-1:0]          rotation;
    logic                               shake_event;

    modport source (
        output valid, orientation, rotation, shake_event,
        input  ready
    );
    modport sink (
        input  valid, orientation, rotation, shake_event,
        output ready
    );
endinterface

@@ src/motion_gesture_classifier_top.sv @@
`timescale 1ns / 1ps
// Path: an accepted sample word updates the window registers and running sums; its
// classification is then written to the result register once that register is free.
// Throughput: one sample word per cycle while the sink takes results, set by the
// single classification stage between the window registers and the result register.
// Reset: rst_n clears both windows, their running sums, the shake phase and start
// time, and loads the default register values; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Motion gesture classifier
// Moving-average windows over accel and gyro samples, with orientation,
// z-rotation and shake detection made exactly on the window sums.
// ----------------------------------------------------------------------------
module motion_gesture_classifier_top (
    input  logic                              clk,
    input  logic                              rst_n,
    mgc_sample_if.sink                        sample,
    mgc_result_if.source                      result,
    input  logic                              cfg_write,
    input  logic [mgc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mgc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mgc_pkg::*;

    // Configuration; gravity and thresholds kept pre-scaled by the window lengths.
    logic [GW_W-1:0]   gw_reg;
    logic [LIM_W-1:0]  rot_thr_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [WIN_W-1:0]  window_reg;

    // Windows and running sums.
    logic signed [SAMPLE_W-1:0]   accel_hist_reg [ACCEL_WINDOW][3];
    logic signed [SAMPLE_W-1:0]   rate_hist_reg  [RATE_WINDOW][3];
    logic signed [ACC_SUM_W-1:0]  acc_sum_reg    [3];
    logic signed [RATE_SUM_W-1:0] rate_sum_reg   [3];
    logic [ACCEL_SLOT_W-1:0]      accel_slot_reg;
    logic [RATE_SLOT_W-1:0]       rate_slot_reg;
    logic [TIME_W-1:0]            time_reg;
    logic                         stage_valid_reg;

    logic signed [SAMPLE_W-1:0]   accel_in [3];
    logic signed [SAMPLE_W-1:0]   rate_in  [3];

    // Shake phase machine.
    shake_phase_t                 phase_reg;
    shake_phase_t                 phase_next;
    logic [TIME_W-1:0]            start_reg;
    logic [TIME_W-1:0]            start_next;
    logic                         shake_hit;

    // Result register.
    logic                         out_valid_reg;
    orient_t                      orient_reg;
    orient_t                      orient_next;
    rotation_t                    rot_reg;
    rotation_t                    rot_next;
    logic                         shake_reg;

    logic                         accept;
    logic                         advance;

    // Classification terms.
    logic signed [CMP_W-1:0]      az2;
    logic signed [CMP_W-1:0]      gw_s;
    logic signed [CMP_W-1:0]      gw3;
    logic signed [2*ACC_SUM_W-1:0] sq_x;
    logic signed [2*ACC_SUM_W-1:0] sq_y;
    logic [2*GW_W-1:0]            gw_sq;
    logic [XY_W-1:0]              axy;
    logic [XY_W-1:0]              gw2;
    logic signed [RCMP_W-1:0]     rz;
    logic signed [RCMP_W-1:0]     thr_s;
    logic [RATE_SUM_W-1:0]        rate_abs [3];
    logic                         calm;
    logic                         timeout;

    assign advance      = stage_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !stage_valid_reg || advance;
    assign accept       = sample.valid && sample.ready;

    assign accel_in[0] = sample.accel_x;
    assign accel_in[1] = sample.accel_y;
    assign accel_in[2] = sample.accel_z;
    assign rate_in[0]  = sample.rate_x;
    assign rate_in[1]  = sample.rate_y;
    assign rate_in[2]  = sample.rate_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg      <= GW_W'(GRAVITY_RESET * ACCEL_WINDOW);
            rot_thr_reg <= LIM_W'(ROT_THR_RESET * RATE_WINDOW);
            limit_reg   <= LIM_W'(SHAKE_LIMIT_RESET * RATE_WINDOW);
            window_reg  <= WIN_W'(SHAKE_WINDOW_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_GRAVITY:      gw_reg      <= GW_W'(cfg_data[GRAV_W-1:0] * ACCEL_WINDOW);
                CFG_ROT_THR:      rot_thr_reg <= LIM_W'(cfg_data[THR_W-1:0] * RATE_WINDOW);
                CFG_SHAKE_LIMIT:  limit_reg   <= LIM_W'(cfg_data[THR_W-1:0] * RATE_WINDOW);
                CFG_SHAKE_WINDOW: window_reg  <= cfg_data[WIN_W-1:0];
                default:          window_reg  <= window_reg;
            endcase
        end
    end

    // The running sums swap the oldest sample of each window for the new one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ACCEL_WINDOW; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    accel_hist_reg[i][k] <= '0;
                end
            end
            for (int i = 0; i < RATE_WINDOW; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rate_hist_reg[i][k] <= '0;
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                acc_sum_reg[k]  <= '0;
                rate_sum_reg[k] <= '0;
            end
            accel_slot_reg  <= '0;
            rate_slot_reg   <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    accel_hist_reg[accel_slot_reg][k] <= accel_in[k];
                    rate_hist_reg[rate_slot_reg][k]   <= rate_in[k];
                    acc_sum_reg[k]  <= acc_sum_reg[k] + ACC_SUM_W'(accel_in[k])
                                       - ACC_SUM_W'(accel_hist_reg[accel_slot_reg][k]);
                    rate_sum_reg[k] <= rate_sum_reg[k] + RATE_SUM_W'(rate_in[k])
                                       - RATE_SUM_W'(rate_hist_reg[rate_slot_reg][k]);
                end
                if (accel_slot_reg == ACCEL_SLOT_W'(ACCEL_WINDOW - 1))
                begin
                    accel_slot_reg <= '0;
                end
                else
                begin
                    accel_slot_reg <= accel_slot_reg + 1'b1;
                end
                if (rate_slot_reg == RATE_SLOT_W'(RATE_WINDOW - 1))
                begin
                    rate_slot_reg <= '0;
                end
                else
                begin
                    rate_slot_reg <= rate_slot_reg + 1'b1;
                end
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            time_reg <= sample.time_ms;
        end
    end

    // Averages against half gravity are compared as 2*sum against G*W, and the
    // x-y magnitude as 4*(sx^2 + sy^2) against (G*W)^2.
    assign az2   = CMP_W'(acc_sum_reg[2]) <<< 1;
    assign gw_s  = $signed(CMP_W'(gw_reg));
    assign gw3   = gw_s + (gw_s <<< 1);
    assign sq_x  = acc_sum_reg[0] * acc_sum_reg[0];
    assign sq_y  = acc_sum_reg[1] * acc_sum_reg[1];
    assign gw_sq = gw_reg * gw_reg;
    assign axy   = (XY_W'($unsigned(sq_x)) + XY_W'($unsigned(sq_y))) << 2;
    assign gw2   = XY_W'(gw_sq);

    assign rz    = RCMP_W'(rate_sum_reg[2]);
    assign thr_s = $signed(RCMP_W'(rot_thr_reg));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rate_abs[k] = rate_sum_reg[k][RATE_SUM_W-1] ? $unsigned(-rate_sum_reg[k])
                                                        : $unsigned(rate_sum_reg[k]);
        end
    end

    assign calm = (rate_abs[0] <= RATE_SUM_W'(limit_reg))
               && (rate_abs[1] <= RATE_SUM_W'(limit_reg))
               && (rate_abs[2] <  RATE_SUM_W'(limit_reg));

    assign timeout = (time_reg - start_reg) > TIME_W'(window_reg);

    always_comb
    begin
        orient_next = ORIENT_UNKNOWN;
        if (az2 > gw_s && axy < gw2)
        begin
            orient_next = ORIENT_UPRIGHT;
        end
        else if (az2 < -gw_s && axy < gw2)
        begin
            orient_next = ORIENT_INVERTED;
        end
        else if (az2 < gw_s && az2 > -gw_s && axy > gw2)
        begin
            orient_next = ORIENT_HORIZONTAL;
        end
    end

    always_comb
    begin
        rot_next = ROT_NONE;
        if (rz > thr_s)
        begin
            rot_next = ROT_POS;
        end
        else if (rz < -thr_s)
        begin
            rot_next = ROT_NEG;
        end
    end

    // Shake phase machine: next state.
    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        if (timeout)
        begin
            phase_next = PHASE_IDLE;
            start_next = time_reg;
        end
        else
        begin
            case (phase_reg)
                PHASE_IDLE:
                begin
                    if (az2 < gw_s && calm)
                    begin
                        phase_next = PHASE_DOWN;
                    end
                end
                PHASE_DOWN:
                begin
                    if (az2 > gw3 && calm)
                    begin
                        phase_next = PHASE_UP;
                    end
                end
                default:
                begin
                    phase_next = PHASE_IDLE;
                    start_next = time_reg;
                end
            endcase
        end
    end

    // Shake phase machine: output.
    always_comb
    begin
        case (phase_reg)
            PHASE_IDLE: shake_hit = 1'b0;
            PHASE_DOWN: shake_hit = 1'b0;
            default:    shake_hit = !timeout;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_IDLE;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg     <= phase_next;
                start_reg     <= start_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            orient_reg <= orient_next;
            rot_reg    <= rot_next;
            shake_reg  <= shake_hit;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.orientation = orient_reg;
    assign result.rotation    = rot_reg;
    assign result.shake_event = shake_reg;

endmodule
